// ===== src/asrd_pkg.sv =====
package asrd_pkg;

  localparam int RAW_W         = 12;
  localparam int OUT_W         = 16;
  localparam int DZ_W          = 16;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int FRAC_BITS_DEF = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_MIN    = 3'd0,
    CFG_X_CENTER = 3'd1,
    CFG_X_MAX    = 3'd2,
    CFG_Y_MIN    = 3'd3,
    CFG_Y_CENTER = 3'd4,
    CFG_Y_MAX    = 3'd5,
    CFG_INNER_DZ = 3'd6,
    CFG_OUTER_DZ = 3'd7
  } cfg_idx_t;

  localparam logic [RAW_W-1:0] MIN_RST    = 12'd0;
  localparam logic [RAW_W-1:0] CENTER_RST = 12'd2048;
  localparam logic [RAW_W-1:0] MAX_RST    = 12'd4095;
  localparam logic [DZ_W-1:0]  INNER_RST  = 16'd9830;
  localparam logic [DZ_W-1:0]  OUTER_RST  = 16'd6554;

  typedef struct packed {
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_x;
    logic signed [OUT_W-1:0] out_y;
    logic                    in_dead_zone;
  } out_t;

endpackage

// ===== src/asrd_axis_lane.sv =====
module asrd_axis_lane #(
  parameter int FRAC_BITS = asrd_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [asrd_pkg::RAW_W-1:0] raw,
  input  logic [asrd_pkg::RAW_W-1:0] lo,
  input  logic [asrd_pkg::RAW_W-1:0] ce,
  input  logic [asrd_pkg::RAW_W-1:0] hi,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [FRAC_BITS:0]         out_mag,
  output logic                       out_neg
);

  localparam int RW = asrd_pkg::RAW_W;
  localparam int NS = FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic [RW:0]          rem;
    logic [RW-1:0]        den;
    logic [FRAC_BITS-1:0] quo;
    logic                 zero;
    logic                 sat;
    logic                 neg;
  } lane_st_t;

  lane_st_t      st_r   [NS];
  lane_st_t      st_nxt [NS];
  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS:0]   rdy;
  logic [RW-1:0] v_clamp;
  logic [RW-1:0] num;
  logic [RW-1:0] den;

  // Clamp is taken low first, as the calibration may place min above max.
  always_comb begin
    v_clamp = raw;
    if (raw < lo) begin
      v_clamp = lo;
    end else if (raw > hi) begin
      v_clamp = hi;
    end
  end

  always_comb begin
    st_nxt[0] = '0;
    if (v_clamp >= ce) begin
      num            = v_clamp - ce;
      den            = hi - ce;
      st_nxt[0].zero = (hi <= ce);
      st_nxt[0].neg  = 1'b0;
    end else begin
      num            = ce - v_clamp;
      den            = ce - lo;
      st_nxt[0].zero = (ce <= lo);
      st_nxt[0].neg  = 1'b1;
    end
    st_nxt[0].rem = {1'b0, num};
    st_nxt[0].den = den;
    // A numerator at or above the span yields a quotient of at least one.
    st_nxt[0].sat = (num >= den);
  end

  for (genvar k = 1; k < NS; k++) begin : g_div
    logic [RW:0] rem2;
    assign rem2 = {st_r[k-1].rem[RW-1:0], 1'b0};
    always_comb begin
      st_nxt[k] = st_r[k-1];
      if (rem2 >= {1'b0, st_r[k-1].den}) begin
        st_nxt[k].rem = rem2 - {1'b0, st_r[k-1].den};
        st_nxt[k].quo = {st_r[k-1].quo[FRAC_BITS-2:0], 1'b1};
      end else begin
        st_nxt[k].rem = rem2;
        st_nxt[k].quo = {st_r[k-1].quo[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  assign v_in = {v_r[NS-2:0], in_valid};

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_neg   = st_r[NS-1].neg;

  always_comb begin
    if (st_r[NS-1].zero) begin
      out_mag = '0;
    end else if (st_r[NS-1].sat) begin
      out_mag = ONE;
    end else begin
      out_mag = {1'b0, st_r[NS-1].quo};
    end
  end

endmodule

// ===== src/asrd_mag.sv =====
module asrd_mag #(
  parameter int FRAC_BITS = asrd_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [FRAC_BITS:0]        ax,
  input  logic [FRAC_BITS:0]        ay,
  input  logic                      neg_x,
  input  logic                      neg_y,
  input  logic [asrd_pkg::DZ_W-1:0] inner,
  input  logic [asrd_pkg::DZ_W-1:0] outer,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [FRAC_BITS:0]        out_ax,
  output logic [FRAC_BITS:0]        out_ay,
  output logic                      out_neg_x,
  output logic                      out_neg_y,
  output logic [FRAC_BITS:0]        out_mag,
  output logic [FRAC_BITS:0]        out_norm,
  output logic                      out_dead
);

  localparam int F    = FRAC_BITS;
  localparam int NS   = 2 * F + 5;
  localparam int SQW  = 2 * F + 2;
  localparam int SRW  = F + 4;
  localparam int NW   = F + 17;
  localparam int S_RT = F + 3;
  localparam int S_DV = F + 5;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  typedef struct packed {
    logic [F:0]     ax;
    logic [F:0]     ay;
    logic           neg_x;
    logic           neg_y;
    logic [SQW-1:0] sq_x;
    logic [SQW-1:0] sq_y;
    logic [SQW-1:0] rad;
    logic [SRW-1:0] srem;
    logic [F:0]     root;
    logic [NW-1:0]  num;
    logic [16:0]    drem;
    logic [F-1:0]   quo;
    logic           dead;
    logic           sat;
  } mag_st_t;

  mag_st_t       st_r   [NS];
  mag_st_t       st_nxt [NS];
  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS:0]   rdy;
  logic [18:0]   rng_full;
  logic          rng_pos;
  logic [16:0]   rng;

  // Span between the two deadzones in Q0.16; only meaningful when positive.
  assign rng_full = 19'd65536 - 19'(inner) - 19'(outer);
  assign rng_pos  = !rng_full[18] && (rng_full != '0);
  assign rng      = rng_full[16:0];

  always_comb begin
    st_nxt[0]       = '0;
    st_nxt[0].ax    = ax;
    st_nxt[0].ay    = ay;
    st_nxt[0].neg_x = neg_x;
    st_nxt[0].neg_y = neg_y;
    st_nxt[0].sq_x  = SQW'(ax * ax);
    st_nxt[0].sq_y  = SQW'(ay * ay);
  end

  always_comb begin
    st_nxt[1]      = st_r[0];
    st_nxt[1].rad  = st_r[0].sq_x + st_r[0].sq_y;
    st_nxt[1].srem = '0;
    st_nxt[1].root = '0;
  end

  // Square root, one result bit per stage, most significant pair first.
  for (genvar k = 2; k < S_RT; k++) begin : g_sqrt
    localparam int J = k - 2;
    logic [SRW-1:0] rem4;
    logic [SRW-1:0] trial;
    assign rem4  = {st_r[k-1].srem[SRW-3:0], st_r[k-1].rad[2*(F-J)+1 -: 2]};
    assign trial = {1'b0, st_r[k-1].root, 2'b01};
    always_comb begin
      st_nxt[k] = st_r[k-1];
      if (rem4 >= trial) begin
        st_nxt[k].srem = rem4 - trial;
        st_nxt[k].root = {st_r[k-1].root[F-1:0], 1'b1};
      end else begin
        st_nxt[k].srem = rem4;
        st_nxt[k].root = {st_r[k-1].root[F-1:0], 1'b0};
      end
    end
  end

  logic [NW-1:0] mag16;
  logic [NW-1:0] inner_q;
  assign mag16   = {st_r[S_RT-1].root, 16'd0};
  assign inner_q = {1'b0, inner, {F{1'b0}}};

  always_comb begin
    st_nxt[S_RT]      = st_r[S_RT-1];
    st_nxt[S_RT].dead = (mag16 <= inner_q);
    st_nxt[S_RT].num  = mag16 - inner_q;
  end

  logic [NW-1:0] rng_sh;
  assign rng_sh = {rng, {F{1'b0}}};

  always_comb begin
    st_nxt[S_RT+1]      = st_r[S_RT];
    st_nxt[S_RT+1].sat  = (st_r[S_RT].num >= rng_sh);
    st_nxt[S_RT+1].drem = st_r[S_RT].num[NW-1:F];
    st_nxt[S_RT+1].quo  = '0;
  end

  for (genvar k = S_DV; k < NS; k++) begin : g_div
    localparam int J = k - S_DV;
    logic [17:0] rem2;
    assign rem2 = {st_r[k-1].drem, st_r[k-1].num[F-1-J]};
    always_comb begin
      st_nxt[k] = st_r[k-1];
      if (rem2 >= {1'b0, rng}) begin
        st_nxt[k].drem = 17'(rem2 - {1'b0, rng});
        st_nxt[k].quo  = {st_r[k-1].quo[F-2:0], 1'b1};
      end else begin
        st_nxt[k].drem = rem2[16:0];
        st_nxt[k].quo  = {st_r[k-1].quo[F-2:0], 1'b0};
      end
    end
  end

  assign v_in = {v_r[NS-2:0], in_valid};

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_ax    = st_r[NS-1].ax;
  assign out_ay    = st_r[NS-1].ay;
  assign out_neg_x = st_r[NS-1].neg_x;
  assign out_neg_y = st_r[NS-1].neg_y;
  assign out_mag   = st_r[NS-1].root;
  assign out_dead  = st_r[NS-1].dead;
  assign out_norm  = (!rng_pos || st_r[NS-1].sat) ? ONE : {1'b0, st_r[NS-1].quo};

endmodule

// ===== src/asrd_scale_lane.sv =====
module asrd_scale_lane #(
  parameter int FRAC_BITS = asrd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [FRAC_BITS:0]                a,
  input  logic                              neg,
  input  logic [FRAC_BITS:0]                norm,
  input  logic [FRAC_BITS:0]                mag,
  input  logic                              dead,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [asrd_pkg::OUT_W-1:0] out_val,
  output logic                              out_dead
);

  localparam int F  = FRAC_BITS;
  localparam int NS = F + 2;
  localparam int PW = 2 * F + 2;
  localparam int VW = (F + 2 > asrd_pkg::OUT_W) ? F + 2 : asrd_pkg::OUT_W;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  typedef struct packed {
    logic [PW-1:0] prod;
    logic [F:0]    mag;
    logic [F:0]    rem;
    logic [F-1:0]  quo;
    logic          neg;
    logic          dead;
    logic          sat;
  } scl_st_t;

  scl_st_t       st_r   [NS];
  scl_st_t       st_nxt [NS];
  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS:0]   rdy;

  always_comb begin
    st_nxt[0]      = '0;
    st_nxt[0].prod = PW'(a * norm);
    st_nxt[0].mag  = mag;
    st_nxt[0].neg  = neg;
    st_nxt[0].dead = dead;
  end

  // The axis never exceeds the magnitude, so the quotient is at most one.
  always_comb begin
    st_nxt[1]     = st_r[0];
    st_nxt[1].sat = (st_r[0].prod >= {1'b0, st_r[0].mag, {F{1'b0}}});
    st_nxt[1].rem = st_r[0].prod[2*F:F];
    st_nxt[1].quo = '0;
  end

  for (genvar k = 2; k < NS; k++) begin : g_div
    localparam int J = k - 2;
    logic [F+1:0] rem2;
    assign rem2 = {st_r[k-1].rem, st_r[k-1].prod[F-1-J]};
    always_comb begin
      st_nxt[k] = st_r[k-1];
      if (rem2 >= {1'b0, st_r[k-1].mag}) begin
        st_nxt[k].rem = (F+1)'(rem2 - {1'b0, st_r[k-1].mag});
        st_nxt[k].quo = {st_r[k-1].quo[F-2:0], 1'b1};
      end else begin
        st_nxt[k].rem = rem2[F:0];
        st_nxt[k].quo = {st_r[k-1].quo[F-2:0], 1'b0};
      end
    end
  end

  assign v_in = {v_r[NS-2:0], in_valid};

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  logic [F:0]    res;
  logic [VW-1:0] res_ext;
  logic [VW-1:0] val;

  always_comb begin
    if (st_r[NS-1].dead) begin
      res = '0;
    end else if (st_r[NS-1].sat) begin
      res = ONE;
    end else begin
      res = {1'b0, st_r[NS-1].quo};
    end
  end

  assign res_ext   = VW'(res);
  assign val       = st_r[NS-1].neg ? (~res_ext + VW'(1)) : res_ext;
  assign out_val   = val[asrd_pkg::OUT_W-1:0];
  assign out_dead  = st_r[NS-1].dead;
  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];

endmodule

// ===== src/analog_stick_radial_deadzone.sv =====
// Radial deadzone conditioning for one analog stick.
// Input channel in_valid/in_stall/in_data carries one raw X,Y sample per
// transfer; the result channel out_valid/out_stall/out_data returns one
// conditioned sample (signed Q1.FRAC_BITS axes and a deadzone flag) per input,
// in order. Calibration and deadzones are written through cfg_we, cfg_index and
// cfg_wdata and take effect immediately. The user must write them only while
// no sample is in flight; the block itself does not enforce it. Throughput is
// one sample per cycle while out_stall is low. The stages are those of the axis
// divider (FRAC_BITS+1), the magnitude root and remap divider (2*FRAC_BITS+5)
// and the scaling divider (FRAC_BITS+2); the bit-serial ones give a bit each.
// X and Y travel in lockstep through two identical axis and scale lanes.
// Each stage holds its own valid bit, so a stall at the output only backs up
// the pipeline as far as it is full: empty stages keep taking transfers, and
// a held result stays stable until it is taken.
// Reset empties the pipeline and restores the default calibration and
// deadzones; no result is presented until a new sample has been taken.
module analog_stick_radial_deadzone #(
  parameter int FRAC_BITS = asrd_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  asrd_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output asrd_pkg::out_t                 out_data,
  input  logic                           cfg_we,
  input  logic [asrd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asrd_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int RW = asrd_pkg::RAW_W;

  logic [RW-1:0]             x_min_r, x_center_r, x_max_r;
  logic [RW-1:0]             y_min_r, y_center_r, y_max_r;
  logic [asrd_pkg::DZ_W-1:0] inner_r, outer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r    <= asrd_pkg::MIN_RST;
      x_center_r <= asrd_pkg::CENTER_RST;
      x_max_r    <= asrd_pkg::MAX_RST;
      y_min_r    <= asrd_pkg::MIN_RST;
      y_center_r <= asrd_pkg::CENTER_RST;
      y_max_r    <= asrd_pkg::MAX_RST;
      inner_r    <= asrd_pkg::INNER_RST;
      outer_r    <= asrd_pkg::OUTER_RST;
    end else if (cfg_we) begin
      case (asrd_pkg::cfg_idx_t'(cfg_index))
        asrd_pkg::CFG_X_MIN:    x_min_r    <= cfg_wdata[RW-1:0];
        asrd_pkg::CFG_X_CENTER: x_center_r <= cfg_wdata[RW-1:0];
        asrd_pkg::CFG_X_MAX:    x_max_r    <= cfg_wdata[RW-1:0];
        asrd_pkg::CFG_Y_MIN:    y_min_r    <= cfg_wdata[RW-1:0];
        asrd_pkg::CFG_Y_CENTER: y_center_r <= cfg_wdata[RW-1:0];
        asrd_pkg::CFG_Y_MAX:    y_max_r    <= cfg_wdata[RW-1:0];
        asrd_pkg::CFG_INNER_DZ: inner_r    <= cfg_wdata;
        asrd_pkg::CFG_OUTER_DZ: outer_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic               ax_in_rdy, ay_in_rdy, ax_vld, ay_vld;
  logic [FRAC_BITS:0] ax_mag, ay_mag;
  logic               ax_neg, ay_neg;
  logic               mg_in_rdy, mg_vld;
  logic [FRAC_BITS:0] mg_ax, mg_ay, mg_mag, mg_norm;
  logic               mg_neg_x, mg_neg_y, mg_dead;
  logic               sx_in_rdy, sy_in_rdy, sx_vld, sy_vld;
  logic               sx_dead, sy_dead;
  logic signed [asrd_pkg::OUT_W-1:0] sx_val, sy_val;

  assign in_stall = !(ax_in_rdy && ay_in_rdy);

  asrd_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(ax_in_rdy),
    .raw(in_data.raw_x), .lo(x_min_r), .ce(x_center_r), .hi(x_max_r),
    .out_valid(ax_vld), .out_ready(mg_in_rdy),
    .out_mag(ax_mag), .out_neg(ax_neg)
  );

  asrd_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(ay_in_rdy),
    .raw(in_data.raw_y), .lo(y_min_r), .ce(y_center_r), .hi(y_max_r),
    .out_valid(ay_vld), .out_ready(mg_in_rdy),
    .out_mag(ay_mag), .out_neg(ay_neg)
  );

  asrd_mag #(.FRAC_BITS(FRAC_BITS)) u_mag (
    .clk(clk), .rst_n(rst_n),
    .in_valid(ax_vld && ay_vld), .in_ready(mg_in_rdy),
    .ax(ax_mag), .ay(ay_mag), .neg_x(ax_neg), .neg_y(ay_neg),
    .inner(inner_r), .outer(outer_r),
    .out_valid(mg_vld), .out_ready(sx_in_rdy && sy_in_rdy),
    .out_ax(mg_ax), .out_ay(mg_ay), .out_neg_x(mg_neg_x), .out_neg_y(mg_neg_y),
    .out_mag(mg_mag), .out_norm(mg_norm), .out_dead(mg_dead)
  );

  asrd_scale_lane #(.FRAC_BITS(FRAC_BITS)) u_scale_x (
    .clk(clk), .rst_n(rst_n),
    .in_valid(mg_vld), .in_ready(sx_in_rdy),
    .a(mg_ax), .neg(mg_neg_x), .norm(mg_norm), .mag(mg_mag), .dead(mg_dead),
    .out_valid(sx_vld), .out_ready(!out_stall),
    .out_val(sx_val), .out_dead(sx_dead)
  );

  asrd_scale_lane #(.FRAC_BITS(FRAC_BITS)) u_scale_y (
    .clk(clk), .rst_n(rst_n),
    .in_valid(mg_vld), .in_ready(sy_in_rdy),
    .a(mg_ay), .neg(mg_neg_y), .norm(mg_norm), .mag(mg_mag), .dead(mg_dead),
    .out_valid(sy_vld), .out_ready(!out_stall),
    .out_val(sy_val), .out_dead(sy_dead)
  );

  assign out_valid             = sx_vld && sy_vld;
  assign out_data.out_x        = sx_val;
  assign out_data.out_y        = sy_val;
  assign out_data.in_dead_zone = sx_dead;

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (ax_vld == ay_vld) && (sx_vld == sy_vld) && (ax_in_rdy == ay_in_rdy))
    else $error("X and Y lanes out of step");

  a_dead_flags_agree: assert property (@(posedge clk) disable iff (!rst_n)
    sx_vld |-> (sx_dead == sy_dead))
    else $error("deadzone flag differs between lanes");

  a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.in_dead_zone) |-> (out_data.out_x == '0 && out_data.out_y == '0))
    else $error("deadzone result with nonzero deflection");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented straight after reset");

endmodule
